// ----- rtl/core/rational_arithmetic_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication
`define RAU_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rational_arithmetic_unit: assertion failed");

// Next-cycle implication
`define RAU_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rational_arithmetic_unit: assertion failed");

`else

`define RAU_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define RAU_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Widths, action codes and item types shared by the unit and its users.
// ----------------------------------------------------------------------------
package rau_pkg;

	// Operand width sets every other width
	localparam int OPERAND_WIDTH = 16;
	localparam int DEN_IN_W      = OPERAND_WIDTH - 1;
	localparam int PROD_W        = 2 * OPERAND_WIDTH;
	localparam int NUM_W         = 2 * OPERAND_WIDTH;
	localparam int DEN_W         = 2 * (OPERAND_WIDTH - 1);
	// magnitude of any cross-product sum fits here
	localparam int MAG_W         = 2 * OPERAND_WIDTH - 1;
	localparam int CNT_W         = $clog2(MAG_W);

	// Action codes
	localparam logic [2:0] ACT_MUL = 3'd0;
	localparam logic [2:0] ACT_DIV = 3'd1;
	localparam logic [2:0] ACT_ADD = 3'd2;
	localparam logic [2:0] ACT_SUB = 3'd3;
	localparam logic [2:0] ACT_EQ  = 3'd4;
	localparam logic [2:0] ACT_LT  = 3'd5;

	typedef struct packed {
		logic [2:0]                      action;
		logic signed [OPERAND_WIDTH-1:0] a_num;
		logic [DEN_IN_W-1:0]             a_den;
		logic signed [OPERAND_WIDTH-1:0] b_num;
		logic [DEN_IN_W-1:0]             b_den;
	} rau_cmd_t;

	typedef struct packed {
		logic signed [NUM_W-1:0] res_num;
		logic [DEN_W-1:0]        res_den;
		logic                    flag;
	} rau_res_t;

endpackage

// ----- rtl/core/rational_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Multiplies, divides, adds, subtracts or compares two fractions.
// One command item on cmd (valid/stall) gives one result item on res.
// Cross products go through one shared signed multiplier, in turn.
// The fraction is reduced by a binary gcd, one halve or subtract-and-halve
// step per cycle, then both parts are divided by the gcd in a restoring
// divider, numerator and denominator side by side, one quotient bit a cycle.
// Compares and results with a zero part skip the gcd and the divider.
// One item is worked on at a time; cmd_stall is high while it is, so a new
// item is taken only once the last one has reached the output register.
// The result sits in an output register: a stalled result holds, and the
// next command is taken meanwhile; it waits in its last step until the
// output register is free. Reset clears the sequencer and res_valid.
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_macros.svh"

module rational_arithmetic_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  rau_pkg::rau_cmd_t cmd,
	output logic              res_valid,
	input  logic              res_stall,
	output rau_pkg::rau_res_t res
);
	import rau_pkg::*;

	localparam int SUM_W = PROD_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_COMB, ST_ABS, ST_GCD, ST_DIV, ST_DONE
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 res_valid_q;
	rau_res_t             res_q;

	rau_cmd_t             op_q;
	logic signed [PROD_W-1:0] p0_q, p1_q, p2_q;
	logic signed [NUM_W-1:0]  num_q;
	logic signed [PROD_W-1:0] den_q;
	logic                 cmp_q;
	logic                 flag_q;
	logic                 neg_q;
	logic [MAG_W-1:0]     gu_q, gv_q, g_q;
	logic [CNT_W-1:0]     k_q;
	logic [MAG_W-1:0]     qn_q, qd_q, rn_n_q, rn_d_q;

	logic signed [OPERAND_WIDTH-1:0] a_den_s, b_den_s, mul_x, mul_y;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [SUM_W-1:0]  sum_w, diff_w;
	logic [NUM_W-1:0]     num_abs;
	logic [PROD_W-1:0]    den_abs;
	logic [MAG_W-1:0]     un, ud;
	logic [MAG_W:0]       tn, td;
	logic                 bn, bd;
	logic                 out_free;
	logic                 mul_last, div_last;
	logic [NUM_W-1:0]     qn_ext;

	// Multiplier operand select: p0, p1, p2 in turn
	assign a_den_s = {1'b0, op_q.a_den};
	assign b_den_s = {1'b0, op_q.b_den};

	always_comb begin
		if (cnt_q == '0) begin
			mul_x = op_q.a_num;
			mul_y = (op_q.action == ACT_MUL) ? op_q.b_num : b_den_s;
		end else if (cnt_q == CNT_W'(1)) begin
			mul_x = op_q.b_num;
			mul_y = a_den_s;
		end else begin
			mul_x = a_den_s;
			mul_y = b_den_s;
		end
	end

	assign mul_p = PROD_W'(mul_x) * PROD_W'(mul_y);

	// Cross-product sums
	assign sum_w  = SUM_W'(p0_q) + SUM_W'(p1_q);
	assign diff_w = SUM_W'(p0_q) - SUM_W'(p1_q);

	// Magnitudes
	assign num_abs = num_q[NUM_W-1] ? (~num_q + 1'b1) : num_q;
	assign den_abs = den_q[PROD_W-1] ? (~den_q + 1'b1) : den_q;
	assign un      = num_abs[MAG_W-1:0];
	assign ud      = den_abs[MAG_W-1:0];

	// Restoring divider step, numerator and denominator side by side
	assign tn = {rn_n_q, qn_q[MAG_W-1]};
	assign td = {rn_d_q, qd_q[MAG_W-1]};
	assign bn = (tn >= {1'b0, g_q});
	assign bd = (td >= {1'b0, g_q});

	assign out_free = !res_valid_q || !res_stall;
	assign mul_last = (cnt_q == CNT_W'(2));
	assign div_last = (cnt_q == CNT_W'(MAG_W - 1));
	assign qn_ext   = NUM_W'(qn_q);

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			// output valid: set on a new result, cleared once taken
			if (state_q == ST_DONE && out_free)
				res_valid_q <= 1'b1;
			else if (res_valid_q && !res_stall)
				res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cnt_q   <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_last) begin
						cnt_q   <= '0;
						state_q <= ST_COMB;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_COMB: state_q <= ST_ABS;
				ST_ABS: begin
					if (cmp_q || un == '0 || ud == '0)
						state_q <= ST_DONE;
					else
						state_q <= ST_GCD;
				end
				ST_GCD: begin
					if (gu_q == gv_q) begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_last) begin
						cnt_q   <= '0;
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						res_q.res_num <= neg_q ? -qn_ext : qn_ext;
						res_q.res_den <= qd_q[DEN_W-1:0];
						res_q.flag    <= flag_q;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid)
					op_q <= cmd;
			end
			ST_MUL: begin
				if (cnt_q == '0)
					p0_q <= mul_p;
				else if (cnt_q == CNT_W'(1))
					p1_q <= mul_p;
				else
					p2_q <= mul_p;
			end
			ST_COMB: begin
				// numerator, denominator and compare flag
				cmp_q <= (op_q.action > ACT_SUB);
				den_q <= (op_q.action == ACT_DIV) ? p1_q : p2_q;
				if (op_q.action == ACT_ADD)
					num_q <= NUM_W'(sum_w);
				else if (op_q.action == ACT_SUB)
					num_q <= NUM_W'(diff_w);
				else
					num_q <= p0_q;
				if (op_q.action == ACT_EQ)
					flag_q <= (p0_q == p1_q);
				else if (op_q.action == ACT_LT)
					flag_q <= (p0_q < p1_q);
				else
					flag_q <= 1'b0;
			end
			ST_ABS: begin
				// signs out, magnitudes into gcd and dividend registers
				rn_n_q <= '0;
				rn_d_q <= '0;
				gu_q   <= un;
				gv_q   <= ud;
				k_q    <= '0;
				if (cmp_q) begin
					neg_q <= 1'b0;
					qn_q  <= '0;
					qd_q  <= MAG_W'(1);
				end else begin
					neg_q <= num_q[NUM_W-1] ^ den_q[PROD_W-1];
					qn_q  <= un;
					qd_q  <= ud;
				end
			end
			ST_GCD: begin
				// binary gcd step: halve evens, else subtract and halve
				priority if (gu_q == gv_q) begin
					g_q <= gu_q << k_q;
				end else if (!gu_q[0] && !gv_q[0]) begin
					gu_q <= gu_q >> 1;
					gv_q <= gv_q >> 1;
					k_q  <= k_q + 1'b1;
				end else if (!gu_q[0]) begin
					gu_q <= gu_q >> 1;
				end else if (!gv_q[0]) begin
					gv_q <= gv_q >> 1;
				end else if (gu_q > gv_q) begin
					gu_q <= (gu_q - gv_q) >> 1;
				end else begin
					gv_q <= (gv_q - gu_q) >> 1;
				end
			end
			ST_DIV: begin
				rn_n_q <= bn ? MAG_W'(tn - {1'b0, g_q}) : tn[MAG_W-1:0];
				rn_d_q <= bd ? MAG_W'(td - {1'b0, g_q}) : td[MAG_W-1:0];
				qn_q   <= {qn_q[MAG_W-2:0], bn};
				qd_q   <= {qd_q[MAG_W-2:0], bd};
			end
			ST_DONE: ;
			default: ;
		endcase
	end

	assign cmd_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Assertions
	`RAU_ASSERT_NXT(a_busy_after_accept, clk, arst_n, cmd_valid && !cmd_stall, cmd_stall)
	`RAU_ASSERT_IMP(a_gcd_nonzero, clk, arst_n, state_q == ST_GCD, gu_q != '0 && gv_q != '0)
	`RAU_ASSERT_IMP(a_rem_below_gcd, clk, arst_n, state_q == ST_DIV, rn_n_q < g_q && rn_d_q < g_q)
	`RAU_ASSERT_IMP(a_exact_division, clk, arst_n, state_q == ST_DONE, rn_n_q == '0 && rn_d_q == '0)
	`RAU_ASSERT_IMP(a_result_from_done, clk, arst_n, $rose(res_valid), $past(state_q) == ST_DONE)

endmodule
